// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define AST_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// checked at every edge, reset included
`define AST_ANY(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define AST_RST(lbl, clk, rst, prop)
`define AST_ANY(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/adt_pkg.sv =====
// ----------------------------------------------------------------------------
// adt_pkg
// Shared constants, register indexes and stage bundles of the target unit.
// ----------------------------------------------------------------------------
package adt_pkg;

  localparam int TGT_W  = 256;
  localparam int OFF_W  = 52;
  localparam int FRAC_W = 16;

  localparam int SPACING_DEF = 600;
  localparam int TAU_DEF     = 172800;
  localparam int FRAC_DEF    = 16;

  localparam logic [63:0] POLY_C1    = 64'd195766423245049;
  localparam logic [63:0] POLY_C2    = 64'd971821376;
  localparam logic [63:0] POLY_C3    = 64'd5127;
  localparam logic [63:0] POLY_ROUND = 64'd1 << 47;

  localparam logic [31:0] CMP_SIGN = 32'h0080_0000;
  localparam logic [31:0] CMP_MANT = 32'h007f_ffff;

  typedef enum logic [2:0] {
    REG_LIM0, REG_LIM1, REG_LIM2, REG_LIM3,
    REG_ALLOW, REG_ATIME, REG_AHEIGHT, REG_ABITS
  } reg_idx_t;

  typedef struct packed {
    logic                    valid;
    logic                    minrule;
    logic signed [OFF_W-1:0] off;
    logic [TGT_W-1:0]        tgt;
  } prep_t;

  typedef struct packed {
    logic              valid;
    logic              minrule;
    logic              big;
    logic              neg;
    logic [7:0]        shamt;
    logic [FRAC_W-1:0] frac;
    logic [TGT_W-1:0]  tgt;
  } shift_t;

  typedef struct packed {
    logic             valid;
    logic             minrule;
    logic             over;
    logic [TGT_W-1:0] tgt;
  } scaled_t;

endpackage

// ===== hw/rtl/asert_difficulty_target.sv =====
// Throughput: one request per cycle; the 15-stage pipeline stalls as a whole
//   only while the output register holds an untaken result.
// Reset: synchronous, active high; empties the pipeline and sets the config
//   registers to their defaults (limit word 3 = 0xFFFFFFFF, all others 0).
// ----------------------------------------------------------------------------
// asert_difficulty_target
// Next compact target from an anchor block and an exponential schedule.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module asert_difficulty_target import adt_pkg::*; #(
  parameter int TARGET_SPACING = SPACING_DEF,
  parameter int TAU_SECONDS    = TAU_DEF,
  parameter int FRACTION_BITS  = FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] prev_time,
  input  logic [30:0] prev_height,
  input  logic [31:0] new_time,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] next_bits,
  output logic        limit_applied,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // Config registers. Written only while the pipeline is empty, a rule the user
  // must keep and that the block does not enforce; so every stage reads them directly.
  logic [63:0] lim [4];
  logic        allow;
  logic [31:0] atime;
  logic [30:0] aheight;
  logic [31:0] abits;

  logic    en;
  prep_t   p1;
  shift_t  p6;
  scaled_t p12;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim[0]  <= '0;
      lim[1]  <= '0;
      lim[2]  <= '0;
      lim[3]  <= 64'h0000_0000_ffff_ffff;
      allow   <= 1'b0;
      atime   <= '0;
      aheight <= '0;
      abits   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LIM0:    lim[0]  <= cfg_data;
        REG_LIM1:    lim[1]  <= cfg_data;
        REG_LIM2:    lim[2]  <= cfg_data;
        REG_LIM3:    lim[3]  <= cfg_data;
        REG_ALLOW:   allow   <= cfg_data[0];
        REG_ATIME:   atime   <= cfg_data[31:0];
        REG_AHEIGHT: aheight <= cfg_data[30:0];
        REG_ABITS:   abits   <= cfg_data[31:0];
        default:     ;
      endcase
    end
  end

  // Whole pipeline advances unless the output holds an untaken result.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: offset, min-difficulty rule, anchor expansion
  adt_prep #(
    .SPACING(TARGET_SPACING)
  ) u_prep (
    .clk, .rst, .en,
    .in_valid, .prev_time, .prev_height, .new_time,
    .allow, .atime, .aheight, .abits,
    .q(p1)
  );

  // stages 2..6: offset / tau into integer shift and fraction
  adt_div #(
    .TAU (TAU_SECONDS),
    .FRAC(FRACTION_BITS)
  ) u_div (
    .clk, .rst, .en,
    .d(p1),
    .q(p6)
  );

  // stages 7..12: shift, polynomial factor, 256x32 scale and add
  adt_scale #(
    .FRAC(FRACTION_BITS)
  ) u_scale (
    .clk, .rst, .en,
    .d(p6),
    .q(p12)
  );

  // stages 13..15: clamp, byte length, compact form
  adt_enc u_enc (
    .clk, .rst, .en,
    .d(p12),
    .lim({lim[3], lim[2], lim[1], lim[0]}),
    .out_valid, .next_bits, .limit_applied
  );

  // pipeline comes out of reset empty
  `AST_ANY(a_rst_empty, clk, rst |=> !out_valid)
  // the compact sign bit is never set
  `AST_RST(a_no_sign, clk, rst, out_valid |-> !next_bits[23])
  // a 256-bit value needs at most 33 size bytes
  `AST_RST(a_size_max, clk, rst, out_valid |-> next_bits[31:24] <= 8'd33)
  // zero size encodes only the zero target
  `AST_RST(a_zero_enc, clk, rst,
           (out_valid && next_bits[31:24] == 8'd0) |-> next_bits[22:0] == 23'd0)

endmodule

// ===== hw/rtl/adt_prep.sv =====
// ----------------------------------------------------------------------------
// adt_prep
// Schedule offset, min-difficulty check and anchor target expansion.
// ----------------------------------------------------------------------------
module adt_prep import adt_pkg::*; #(
  parameter int SPACING = SPACING_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] prev_time,
  input  logic [30:0] prev_height,
  input  logic [31:0] new_time,
  input  logic        allow,
  input  logic [31:0] atime,
  input  logic [30:0] aheight,
  input  logic [31:0] abits,
  output prep_t       q
);

  localparam logic signed [OFF_W-1:0] SP = OFF_W'(SPACING);

  logic signed [33:0]      dt;
  logic signed [32:0]      dh;
  logic signed [OFF_W-1:0] dh_x;
  logic signed [OFF_W-1:0] off;
  logic                    minrule;
  logic [7:0]              size;
  logic [22:0]             mant;
  logic [4:0]              ls;
  logic [TGT_W-1:0]        tgt;

  assign dt   = $signed({2'b00, prev_time}) - $signed({2'b00, atime});
  assign dh   = $signed({2'b00, prev_height}) - $signed({2'b00, aheight}) + 33'sd1;
  assign dh_x = OFF_W'(dh);
  assign off  = OFF_W'(dt) - dh_x * SP;

  assign minrule = allow && ({2'b00, new_time} > ({2'b00, prev_time} + 34'(2 * SPACING)));

  assign size = abits[31:24];
  assign mant = abits[22:0];
  assign ls   = 5'(size - 8'd3);

  always_comb begin
    tgt = '0;
    if (size <= 8'd3) begin
      tgt = TGT_W'(mant >> {(2'd3 - size[1:0]), 3'b000});
    end else if (size < 8'd35) begin
      tgt = TGT_W'(mant) << {ls, 3'b000};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= in_valid;
    end
    if (en) begin
      q.minrule <= minrule;
      q.off     <= off;
      q.tgt     <= tgt;
    end
  end

endmodule

// ===== hw/rtl/adt_div.sv =====
// ----------------------------------------------------------------------------
// adt_div
// Offset divided by tau: reciprocal multiply with one correction, twice.
// ----------------------------------------------------------------------------
module adt_div import adt_pkg::*; #(
  parameter int TAU  = TAU_DEF,
  parameter int FRAC = FRAC_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  prep_t  d,
  output shift_t q
);

  localparam int L = $clog2(TAU);
  localparam int K = 31 + L;
  localparam logic [31:0]      RECIP = 32'((64'd1 << K) / TAU);
  localparam logic [OFF_W-1:0] SAT   = OFF_W'(64'(TAU) << 8);
  localparam logic [31:0]      TAU32 = 32'(TAU);

  // stage 2
  logic [OFF_W-1:0] mag;
  logic             s2_v, s2_min, s2_neg, s2_sat;
  logic [31:0]      s2_m;
  logic [63:0]      s2_p;
  logic [TGT_W-1:0] s2_t;
  // stage 3
  logic [8:0]       qe;
  logic             s3_v, s3_min, s3_neg, s3_sat;
  logic [8:0]       s3_q;
  logic [31:0]      s3_r;
  logic [TGT_W-1:0] s3_t;
  // stage 4
  logic [8:0]       qc;
  logic [31:0]      rc;
  logic             s4_v, s4_min, s4_neg, s4_sat;
  logic [8:0]       s4_q;
  logic [31:0]      s4_r;
  logic [63:0]      s4_rp;
  logic [TGT_W-1:0] s4_t;
  // stage 5
  logic [FRAC-1:0]  fe;
  logic             s5_v, s5_min, s5_neg, s5_sat;
  logic [8:0]       s5_q;
  logic [FRAC-1:0]  s5_fe;
  logic [47:0]      s5_d;
  logic [TGT_W-1:0] s5_t;
  // stage 6
  logic [FRAC-1:0]  fq;
  logic [8:0]       whole;
  logic [FRAC-1:0]  frac;

  assign mag = d.off[OFF_W-1] ? OFF_W'(-d.off) : OFF_W'(d.off);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= d.valid;
    end
    if (en) begin
      s2_min <= d.minrule;
      s2_neg <= d.off[OFF_W-1];
      s2_sat <= mag >= SAT;
      s2_m   <= mag[31:0];
      s2_p   <= 64'(mag[31:0]) * 64'(RECIP);
      s2_t   <= d.tgt;
    end
  end

  assign qe = 9'(s2_p >> K);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
    if (en) begin
      s3_min <= s2_min;
      s3_neg <= s2_neg;
      s3_sat <= s2_sat;
      s3_q   <= qe;
      s3_r   <= s2_m - 32'(32'(qe) * TAU32);
      s3_t   <= s2_t;
    end
  end

  always_comb begin
    qc = s3_q;
    rc = s3_r;
    if (s3_r >= TAU32) begin
      qc = s3_q + 9'd1;
      rc = s3_r - TAU32;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
    if (en) begin
      s4_min <= s3_min;
      s4_neg <= s3_neg;
      s4_sat <= s3_sat;
      s4_q   <= qc;
      s4_r   <= rc;
      s4_rp  <= 64'(rc) * 64'(RECIP);
      s4_t   <= s3_t;
    end
  end

  assign fe = FRAC'(s4_rp >> (K - FRAC));

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
    if (en) begin
      s5_min <= s4_min;
      s5_neg <= s4_neg;
      s5_sat <= s4_sat;
      s5_q   <= s4_q;
      s5_fe  <= fe;
      s5_d   <= (48'(s4_r) << FRAC) - 48'(48'(fe) * 48'(TAU));
      s5_t   <= s4_t;
    end
  end

  // negative offsets round the exponent down: whole+1, 1 - frac
  always_comb begin
    fq    = (s5_d >= 48'(TAU)) ? s5_fe + FRAC'(1) : s5_fe;
    whole = s5_q;
    frac  = fq;
    if (s5_neg && (fq != '0)) begin
      whole = s5_q + 9'd1;
      frac  = FRAC'(-fq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= s5_v;
    end
    if (en) begin
      q.minrule <= s5_min;
      q.big     <= s5_sat | whole[8];
      q.neg     <= s5_neg;
      q.shamt   <= whole[7:0];
      q.frac    <= FRAC_W'(frac);
      q.tgt     <= s5_t;
    end
  end

endmodule

// ===== hw/rtl/adt_scale.sv =====
// ----------------------------------------------------------------------------
// adt_scale
// Target shift by the integer exponent and cubic 2^frac scaling.
// ----------------------------------------------------------------------------
module adt_scale import adt_pkg::*; #(
  parameter int FRAC = FRAC_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  shift_t  d,
  output scaled_t q
);

  // stage 7
  logic [2*TGT_W-1:0] wide;
  logic [TGT_W-1:0]   t7;
  logic               o7;
  logic               s7_v, s7_min, s7_over;
  logic [TGT_W-1:0]   s7_t;
  logic [FRAC_W-1:0]  s7_f;
  logic [31:0]        s7_f2;
  logic [63:0]        s7_p1;
  // stage 8
  logic               s8_v, s8_min, s8_over;
  logic [TGT_W-1:0]   s8_t;
  logic [63:0]        s8_p1, s8_p2;
  logic [47:0]        s8_f3;
  // stage 9
  logic [63:0]        psum, factor;
  logic               s9_v, s9_min, s9_over;
  logic [TGT_W-1:0]   s9_t;
  logic [31:0]        s9_fac;
  // stage 10
  logic               s10_v, s10_min, s10_over;
  logic [TGT_W-1:0]   s10_t;
  logic [63:0]        s10_pr [8];
  // stage 11
  logic               s11_v, s11_min, s11_over;
  logic [TGT_W-1:0]   s11_t;
  logic [TGT_W+31:0]  s11_prod;
  // stage 12
  logic [TGT_W+31:0]  sh;
  logic [TGT_W:0]     tot;

  assign wide = {{TGT_W{1'b0}}, d.tgt} << d.shamt;

  always_comb begin
    t7 = wide[TGT_W-1:0];
    o7 = |wide[2*TGT_W-1:TGT_W];
    if (d.big) begin
      t7 = '0;
      o7 = !d.neg && (|d.tgt);
    end else if (d.neg) begin
      t7 = d.tgt >> d.shamt;
      o7 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= d.valid;
    end
    if (en) begin
      s7_min  <= d.minrule;
      s7_over <= o7;
      s7_t    <= t7;
      s7_f    <= d.frac;
      s7_f2   <= 32'(d.frac) * 32'(d.frac);
      s7_p1   <= POLY_C1 * 64'(d.frac);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (en) begin
      s8_v <= s7_v;
    end
    if (en) begin
      s8_min  <= s7_min;
      s8_over <= s7_over;
      s8_t    <= s7_t;
      s8_p1   <= s7_p1;
      s8_p2   <= POLY_C2 * 64'(s7_f2);
      s8_f3   <= 48'(s7_f2) * 48'(s7_f);
    end
  end

  // wraps at 64 bits like the polynomial definition
  assign psum   = s8_p1 + s8_p2 + (POLY_C3 * 64'(s8_f3)) + POLY_ROUND;
  assign factor = psum >> (3 * FRAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (en) begin
      s9_v <= s8_v;
    end
    if (en) begin
      s9_min  <= s8_min;
      s9_over <= s8_over | ((factor[63:32] != '0) && (|s8_t));
      s9_t    <= s8_t;
      s9_fac  <= factor[31:0];
    end
  end

  // one 32x32 lane per target limb
  for (genvar i = 0; i < 8; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en) begin
        s10_pr[i] <= 64'(s9_t[32*i +: 32]) * 64'(s9_fac);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
    end else if (en) begin
      s10_v <= s9_v;
    end
    if (en) begin
      s10_min  <= s9_min;
      s10_over <= s9_over;
      s10_t    <= s9_t;
    end
  end

  // even lanes sit on 64-bit boundaries, odd lanes 32 bits up
  always_ff @(posedge clk) begin
    if (rst) begin
      s11_v <= 1'b0;
    end else if (en) begin
      s11_v <= s10_v;
    end
    if (en) begin
      s11_min  <= s10_min;
      s11_over <= s10_over;
      s11_t    <= s10_t;
      s11_prod <= {32'b0, s10_pr[6], s10_pr[4], s10_pr[2], s10_pr[0]}
                + {s10_pr[7], s10_pr[5], s10_pr[3], s10_pr[1], 32'b0};
    end
  end

  assign sh  = s11_prod >> FRAC;
  assign tot = {1'b0, s11_t} + {1'b0, sh[TGT_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= s11_v;
    end
    if (en) begin
      q.minrule <= s11_min;
      q.over    <= s11_over | tot[TGT_W] | (|sh[TGT_W+31:TGT_W]);
      q.tgt     <= tot[TGT_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/adt_enc.sv =====
// ----------------------------------------------------------------------------
// adt_enc
// Limit clamp and compact encoding; last stage is the output register.
// ----------------------------------------------------------------------------
module adt_enc import adt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  scaled_t          d,
  input  logic [TGT_W-1:0] lim,
  output logic             out_valid,
  output logic [31:0]      next_bits,
  output logic             limit_applied
);

  logic             sel;
  logic             s13_v, s13_flag;
  logic [TGT_W-1:0] s13_val;
  logic [5:0]       size;
  logic             s14_v, s14_flag;
  logic [TGT_W-1:0] s14_val;
  logic [5:0]       s14_size;
  logic [31:0]      c;
  logic [7:0]       sz8;

  assign sel = d.minrule | d.over | (d.tgt > lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      s13_v <= 1'b0;
    end else if (en) begin
      s13_v <= d.valid;
    end
    if (en) begin
      s13_flag <= sel;
      s13_val  <= sel ? lim : d.tgt;
    end
  end

  // byte length of the value
  always_comb begin
    size = '0;
    for (int i = 0; i < TGT_W / 8; i++) begin
      if (s13_val[8*i +: 8] != '0) begin
        size = 6'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s14_v <= 1'b0;
    end else if (en) begin
      s14_v <= s13_v;
    end
    if (en) begin
      s14_flag <= s13_flag;
      s14_val  <= s13_val;
      s14_size <= size;
    end
  end

  always_comb begin
    sz8 = 8'(s14_size);
    if (s14_size <= 6'd3) begin
      c = s14_val[31:0] << {(2'd3 - s14_size[1:0]), 3'b000};
    end else begin
      c = 32'(s14_val >> {(s14_size - 6'd3), 3'b000});
    end
    // keep the sign bit clear
    if ((c & CMP_SIGN) != '0) begin
      c   = c >> 8;
      sz8 = sz8 + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s14_v;
    end
    if (en) begin
      next_bits     <= {sz8, 24'(c & CMP_MANT)};
      limit_applied <= s14_flag;
    end
  end

endmodule

// ===== tb/asert_target_checker.sv =====
// ----------------------------------------------------------------------------
// asert_target_checker
// Watches the request, result and config channels of the target unit, works
// out the expected compact target of every accepted request and compares it
// field by field with the results in order.
// ----------------------------------------------------------------------------
module asert_target_checker import adt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] prev_time,
  input  logic [30:0] prev_height,
  input  logic [31:0] new_time,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] next_bits,
  input  logic        limit_applied,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SPACING = SPACING_DEF;
  localparam longint TAU     = TAU_DEF;
  localparam int     FB      = FRAC_DEF;

  typedef struct packed {
    logic [31:0] bits;
    logic        lim;
  } target_t;

  logic [255:0] lim_val;
  logic         allow;
  logic [31:0]  atime;
  logic [30:0]  aheight;
  logic [31:0]  abits;
  target_t      target_q[$];

  assign pending = target_q.size();

  function automatic logic [31:0] compact_of(logic [255:0] v);
    int nbits, sz;
    logic [255:0] t;
    logic [31:0] c;
    nbits = 0;
    for (int i = 255; i >= 0; i--) begin
      if (v[i]) begin
        nbits = i + 1;
        break;
      end
    end
    sz = (nbits + 7) / 8;
    if (sz <= 3) c = v[31:0] << (8 * (3 - sz));
    else begin
      t = v >> (8 * (sz - 3));
      c = t[31:0];
    end
    if (c & CMP_SIGN) begin
      c = c >> 8;
      sz++;
    end
    return (c & CMP_MANT) | (32'(sz) << 24);
  endfunction

  function automatic target_t next_target(logic [31:0] pt, logic [30:0] ph,
                                          logic [31:0] nt);
    target_t r;
    logic [511:0] wide;
    logic [255:0] tgt;
    logic [63:0] mag, whole, fq, frac, factor;
    logic [319:0] prod;
    logic [320:0] sum;
    longint off;
    int sz;
    logic over;
    over = 1'b0;
    if (allow && longint'(nt) > longint'(pt) + 2 * SPACING) begin
      r.bits = compact_of(lim_val);
      r.lim  = 1'b1;
      return r;
    end
    sz = abits[31:24];
    tgt = '0;
    if (sz <= 3) tgt = 256'(abits[22:0] >> (8 * (3 - sz)));
    else if (8 * (sz - 3) < 256) tgt = 256'(abits[22:0]) << (8 * (sz - 3));
    off = (longint'(pt) - longint'(atime))
        - SPACING * ((longint'(ph) - longint'(aheight)) + 1);
    mag   = off < 0 ? -off : off;
    whole = mag / TAU;
    fq    = ((mag % TAU) << FB) / TAU;
    if (off >= 0) begin
      frac = fq;
      if (whole >= 256) begin
        over = tgt != 0;
        tgt  = '0;
      end else begin
        wide = 512'(tgt) << whole;
        over = wide[511:256] != 0;
        tgt  = wide[255:0];
      end
    end else begin
      if (fq != 0) begin
        whole++;
        frac = (64'd1 << FB) - fq;
      end else frac = 0;
      tgt = whole >= 256 ? '0 : tgt >> whole;
    end
    if (!over) begin
      factor = (POLY_C1 * frac + POLY_C2 * frac * frac
              + POLY_C3 * frac * frac * frac + POLY_ROUND) >> (3 * FB);
      // only the low 32 bits multiply; a wider factor with a nonzero
      // target is an overflow
      prod = 320'(tgt) * 320'(factor[31:0]);
      if (factor[63:32] != 0 && tgt != 0) over = 1'b1;
      prod = prod >> FB;
      sum  = 321'(tgt) + 321'(prod[255:0]);
      if (sum[256] || prod[319:256] != 0) over = 1'b1;
      tgt = sum[255:0];
    end
    if (!over && tgt > lim_val) over = 1'b1;
    r.bits = compact_of(over ? lim_val : tgt);
    r.lim  = over;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    target_t want;
    if (rst) begin
      lim_val <= {64'hffff_ffff, 192'd0};
      allow   <= 1'b0;
      atime   <= '0;
      aheight <= '0;
      abits   <= '0;
      errors  <= 0;
      target_q.delete();
    end else begin
      if (in_valid && !in_stall)
        target_q.push_back(next_target(prev_time, prev_height, new_time));
      if (out_valid && !out_stall) begin
        if (target_q.size() == 0) begin
          $display("%0t: result with no request waiting", $realtime);
          errors++;
        end else begin
          want = target_q.pop_front();
          if (next_bits !== want.bits) report_mismatch("next_bits", next_bits, want.bits);
          if (limit_applied !== want.lim)
            report_mismatch("limit_applied", 32'(limit_applied), 32'(want.lim));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_LIM0:    lim_val[63:0]    <= cfg_data;
          REG_LIM1:    lim_val[127:64]  <= cfg_data;
          REG_LIM2:    lim_val[191:128] <= cfg_data;
          REG_LIM3:    lim_val[255:192] <= cfg_data;
          REG_ALLOW:   allow   <= cfg_data[0];
          REG_ATIME:   atime   <= cfg_data[31:0];
          REG_AHEIGHT: aheight <= cfg_data[30:0];
          REG_ABITS:   abits   <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/tb_asert_difficulty_target.sv =====
// ----------------------------------------------------------------------------
// tb_asert_difficulty_target
// Drives header requests and config phases into the target unit with random
// idle and stall patterns; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module tb_asert_difficulty_target import adt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 15;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0, in_stall;
  logic [31:0] prev_time = '0, new_time = '0;
  logic [30:0] prev_height = '0;
  logic        out_valid, out_stall = 1'b0;
  logic [31:0] next_bits;
  logic        limit_applied;
  logic        cfg_valid = 1'b0, cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          errors, pending;
  int          send_idle_pct, recv_stall_pct;
  int          cycles = 0;
  // mirror of the anchor so requests land near the schedule
  logic [31:0] a_time;
  logic [30:0] a_height;

  always #5 clk = ~clk;

  asert_difficulty_target u_top (.*);

  asert_target_checker u_chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side stalls at random
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  task automatic write_reg(reg_idx_t idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one header request; waits for acceptance
  task automatic send_header(logic [31:0] pt, logic [30:0] ph, logic [31:0] nt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    prev_time   <= pt;
    prev_height <= ph;
    new_time    <= nt;
    do @(posedge clk); while (in_stall);
  endtask

  // one idle edge first so the last accepted request is already counted
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // mostly near-schedule headers, some wild ones
  task automatic random_header();
    logic [30:0] dh;
    int drift;
    logic [31:0] pt, nt;
    dh    = $urandom_range(5000);
    drift = $urandom_range(1, 6) == 1 ? $urandom : int'($urandom_range(4000000)) - 2000000;
    pt    = a_time + 32'(600 * (dh + 1)) + 32'(drift);
    nt    = pt + 32'($urandom_range(2400));
    case ($urandom_range(9))
      0: send_header($urandom, 31'($urandom), $urandom);
      1: send_header(pt, a_height + dh, $urandom);
      default: send_header(pt, a_height + dh, nt);
    endcase
  endtask

  task automatic set_anchor(logic [31:0] t, logic [30:0] h, logic [31:0] b);
    a_time = t;
    a_height = h;
    write_reg(REG_ATIME, 64'(t));
    write_reg(REG_AHEIGHT, 64'(h));
    write_reg(REG_ABITS, 64'(b));
  endtask

  initial begin
    send_idle_pct  = 16;
    recv_stall_pct = 53;
    a_time = '0;
    a_height = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset config, extremes of the fields
    send_header('0, '0, '0);
    send_header('1, '1, '1);
    send_header(32'hffff_ffff, '0, '0);
    send_header('0, 31'h7fff_ffff, '0);
    drain();
    write_reg(REG_LIM3, 64'h0000_0000_ffff_ffff);
    write_reg(REG_LIM2, '1);
    write_reg(REG_LIM1, '1);
    write_reg(REG_LIM0, '1);
    write_reg(REG_ALLOW, 64'd1);
    set_anchor(32'd1000000, 31'd100, 32'h1d00_ffff);
    // on schedule, min rule at and past its edge, big up/down offsets
    send_header(32'd1000000, 31'd99, 32'd1000000);
    send_header(32'd1000000, 31'd99, 32'd1001200);
    send_header(32'd1000000, 31'd99, 32'd1001201);
    send_header(32'hffff_ffff, 31'd100, 32'd0);
    send_header(32'd0, 31'h7fff_ffff, 32'd0);
    send_header(32'd1172800, 31'd99, 32'd0);
    send_header(32'd827200, 31'd99, 32'd0);
    send_header(32'd1000001, 31'd99, 32'd0);
    drain();
    // sign bit set, tiny and oversize exponents, target above the limit
    set_anchor(32'hffff_ffff, 31'h7fff_ffff, 32'h03ff_ffff);
    send_header(32'hffff_ffff, 31'h7fff_fffe, 32'd0);
    send_header(32'hffff_ffff, 31'h7fff_ffff, 32'd0);
    drain();
    set_anchor(32'd0, 31'd0, 32'h2200_1234);
    send_header(32'd0, 31'd0, 32'd0);
    send_header(32'd600, 31'd0, 32'd0);
    drain();
    write_reg(REG_LIM0, 64'd0);
    write_reg(REG_LIM1, 64'd0);
    write_reg(REG_LIM2, 64'd0);
    write_reg(REG_LIM3, 64'h0000_0000_ffff_0000);
    set_anchor(32'd5000, 31'd10, 32'h2000_ffff);
    send_header(32'd5000, 31'd9, 32'd0);
    send_header(32'd5000, 31'd10, 32'd0);
    drain();

    // random phases: idle schemes rotate, config changes between phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 16; recv_stall_pct = 53; end
        1: begin send_idle_pct = 53; recv_stall_pct = 16; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_reg(REG_ALLOW, 64'($urandom_range(1)));
      if (ph == 7) begin
        write_reg(REG_LIM0, '1);
        write_reg(REG_LIM1, '1);
        write_reg(REG_LIM2, '1);
        write_reg(REG_LIM3, '1);
      end else begin
        write_reg(REG_LIM0, {$urandom, $urandom});
        write_reg(REG_LIM1, {$urandom, $urandom});
        write_reg(REG_LIM2, {$urandom, $urandom});
        write_reg(REG_LIM3, 64'({$urandom, $urandom}) >> $urandom_range(63));
      end
      set_anchor($urandom, 31'($urandom),
                 ($urandom_range(3) == 0) ? $urandom
                   : {8'($urandom_range(3, 33)), 1'b0, 23'($urandom)});
      for (int k = 0; k < 200; k++) begin
        random_header();
        // sender hold-off until everything is back
        if (k == 100) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/adt_pkg.sv
hw/rtl/adt_prep.sv
hw/rtl/adt_div.sv
hw/rtl/adt_scale.sv
hw/rtl/adt_enc.sv
hw/rtl/asert_difficulty_target.sv
tb/asert_target_checker.sv
tb/tb_asert_difficulty_target.sv
